FILE: hdl/lir_pkg.sv
package lir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 16;
  localparam int COUNT_W  = 13;
  localparam int CFG_W    = 16;
  localparam int NUM_W    = POS_W + COUNT_W;
  localparam int TDATA_W  = 32;

  // configuration register indexes
  localparam logic REG_IN_FRAMES  = 1'b0;
  localparam logic REG_OUT_FRAMES = 1'b1;

  // request kinds on s_tuser
  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [COUNT_W-1:0]         count_t;

endpackage

FILE: hdl/linear_interpolation_resampler.sv
// Linear interpolation resampler. Write requests (s_tuser = 0) store a Q1.15
// sample at the given input index in a single-port sample RAM. A compute
// request (s_tuser = 1) for output index i returns floor interpolation between
// the samples at floor(i*in/out) and the next one, with a FRACTION_BITS
// fraction; the last sample is repeated at the block end, and an index at or
// past out_frame_count returns zero with m_tuser set. The bit-serial divider
// produces position and fraction together. The input is ready again in the
// cycle the result appears. An out-of-range request skips the computation
// states and goes straight to the finish state, then to the result register.
// One request is worked at a time; the result register lets the next request
// in while a result waits, and a request finishing while that register is
// still full holds until the result is taken.
// Reading a RAM entry never written since reset gives an undefined sample.
module linear_interpolation_resampler #(
  parameter int MAX_INPUT_FRAMES = 4096,
  parameter int FRACTION_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lir_pkg::TDATA_W-1:0]   s_tdata,   // position[15:0], write_sample[31:16]
  input  logic                          s_tuser,   // req_type
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lir_pkg::TDATA_W-1:0]   m_tdata,   // out_sample[15:0], out_position[31:16]
  output logic                          m_tuser,   // out_of_range
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [lir_pkg::CFG_W-1:0]     cfg_data
);
  import lir_pkg::*;

  localparam int AW   = $clog2(MAX_INPUT_FRAMES);
  localparam int Q_W  = COUNT_W + FRACTION_BITS;
  localparam int PW   = SAMPLE_W + FRACTION_BITS + 2;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL    = 4'd1;
  localparam logic [3:0] ST_DSTART = 4'd2;
  localparam logic [3:0] ST_DIV    = 4'd3;
  localparam logic [3:0] ST_RDA    = 4'd4;
  localparam logic [3:0] ST_RDB    = 4'd5;
  localparam logic [3:0] ST_GETB   = 4'd6;
  localparam logic [3:0] ST_PROD   = 4'd7;
  localparam logic [3:0] ST_SUM    = 4'd8;
  localparam logic [3:0] ST_FIN    = 4'd9;

  logic [3:0]   state;
  count_t       in_count;
  pos_t         out_count;

  pos_t         in_pos;
  sample_t      in_sample;
  logic         s_xfer;

  pos_t         req_pos;
  logic [NUM_W-1:0] num;
  logic         div_done;
  logic [Q_W-1:0] div_quot;
  count_t       whole;
  logic [FRACTION_BITS-1:0] frac;
  logic [COUNT_W:0] next_idx;

  logic         ram_we;
  logic [AW-1:0] ram_addr;
  sample_t      ram_rdata;

  sample_t      a_smp;
  logic signed [SAMPLE_W:0] diff;
  logic signed [PW-1:0] prod;
  logic signed [SAMPLE_W+1:0] sum_wide;
  sample_t      res;
  logic         res_oor;

  logic [COUNT_W-1:0] cfg_cnt;

  assign in_pos    = s_tdata[POS_W-1:0];
  assign in_sample = s_tdata[POS_W+SAMPLE_W-1:POS_W];
  assign s_tready  = (state == ST_IDLE);
  assign s_xfer    = s_tvalid && s_tready;

  assign whole    = div_quot[Q_W-1:FRACTION_BITS];
  assign frac     = div_quot[FRACTION_BITS-1:0];
  assign next_idx = {1'b0, whole} + 1'b1;

  // configuration; the input count saturates to 1..MAX_INPUT_FRAMES
  assign cfg_cnt = cfg_data[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= COUNT_W'(1);
      out_count <= POS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_FRAMES: begin
          if (cfg_cnt == '0) begin
            in_count <= COUNT_W'(1);
          end else if ({19'd0, cfg_cnt} > MAX_INPUT_FRAMES) begin
            in_count <= COUNT_W'(MAX_INPUT_FRAMES);
          end else begin
            in_count <= cfg_cnt;
          end
        end
        REG_OUT_FRAMES: out_count <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // RAM port: writes on accept, reads of the sample pair after the divide
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = AW'(in_pos);
    case (state)
      ST_IDLE: begin
        ram_we = s_xfer && (s_tuser == REQ_WRITE) &&
                 ({1'b0, in_pos} < (POS_W+1)'(MAX_INPUT_FRAMES));
      end
      ST_RDA:  ram_addr = AW'(whole);
      ST_RDB:  ram_addr = AW'(next_idx);
      default: ;
    endcase
  end

  lir_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_INPUT_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_sample),
    .rdata (ram_rdata)
  );

  lir_div #(
    .FRAC_W (FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_DSTART),
    .num   (num),
    .den   (out_count),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_xfer && (s_tuser == REQ_COMPUTE)) begin
            state <= (in_pos >= out_count) ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL:    state <= ST_DSTART;
        ST_DSTART: state <= ST_DIV;
        ST_DIV:    if (div_done) state <= ST_RDA;
        ST_RDA:    state <= ST_RDB;
        ST_RDB:    state <= (next_idx >= {1'b0, in_count}) ? ST_FIN : ST_GETB;
        ST_GETB:   state <= ST_PROD;
        ST_PROD:   state <= ST_SUM;
        ST_SUM:    state <= ST_FIN;
        ST_FIN:    if (!m_tvalid || m_tready) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // floor((ua*(1-f) + ub*f)) reduces to a + floor((b-a)*f / 2^FRACTION_BITS)
  assign sum_wide = (SAMPLE_W+2)'(a_smp) + prod[PW-1:FRACTION_BITS];

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          req_pos <= in_pos;
          res     <= '0;
          res_oor <= (in_pos >= out_count);
        end
      end
      ST_MUL:  num   <= NUM_W'(req_pos * in_count);
      ST_RDB: begin
        a_smp <= ram_rdata;
        res   <= ram_rdata;
      end
      ST_GETB: diff  <= (SAMPLE_W+1)'(ram_rdata) - (SAMPLE_W+1)'(a_smp);
      ST_PROD: prod  <= PW'(diff * $signed({1'b0, frac}));
      ST_SUM:  res   <= sum_wide[SAMPLE_W-1:0];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= {req_pos, res};
      m_tuser <= res_oor;
    end
  end

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[SAMPLE_W-1:0] == '0)
    else $error("out-of-range result with nonzero sample");

  a_in_count_range: assert property (@(posedge clk) disable iff (rst)
    in_count != '0 && {19'd0, in_count} <= MAX_INPUT_FRAMES)
    else $error("input frame count outside its range");

  a_read_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_RDB |-> $past(state) == ST_RDA)
    else $error("second sample read without first");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_IDLE)
    else $error("sample write during a computation");

endmodule

FILE: hdl/lir_ram.sv
module lir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/lir_div.sv
// Restoring divider, one quotient bit per cycle.
// Divides {num, FRAC_W zeros} by den; caller guarantees the quotient fits
// COUNT_W + FRAC_W bits, so the top POS_W bits of num are below den.
module lir_div #(
  parameter int FRAC_W = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [lir_pkg::NUM_W-1:0]           num,
  input  logic [lir_pkg::POS_W-1:0]           den,
  output logic                                done,
  output logic [lir_pkg::COUNT_W+FRAC_W-1:0]  quot
);
  import lir_pkg::*;

  localparam int Q_W   = COUNT_W + FRAC_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [POS_W-1:0] rem;
  logic [Q_W-1:0]   sh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [POS_W:0]   trial;
  logic             ge;

  always_comb begin
    trial = {rem, sh[Q_W-1]};
    ge    = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend bits shift out of the top of sh while quotient bits enter below
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[NUM_W-1:COUNT_W];
      sh  <= {num[COUNT_W-1:0], {FRAC_W{1'b0}}};
    end else if (busy) begin
      rem <= ge ? POS_W'(trial - {1'b0, den}) : trial[POS_W-1:0];
      sh  <= {sh[Q_W-2:0], ge};
    end
  end

  assign quot = sh;

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < den) else $error("divider partial remainder not below divisor");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("divider did not start");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("divider done without a run");

endmodule

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lir_pkg::*;

  localparam int MAX_FRAMES = 4096;
  localparam int FRAC_BITS = 16;
  localparam int PHASES = 14;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    sample_t smp;
    pos_t    pos;
    logic    oor;
  } out_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        sel;       // request kind or register index
    pos_t        pos;
    logic [15:0] value;     // sample for items, data for registers
    logic        typed;
    sample_t     want_smp;
    logic        want_oor;
  } stim_row_t;

  // Starts in the reset setting (1 input frame, 1 output frame).
  localparam stim_row_t DIRECTED_ROWS [24] = '{
    '{ROW_ITEM, REQ_WRITE,      16'd0,     16'h7FFF, 1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_COMPUTE,    16'd0,     16'h0000, 1'b1, 16'sh7FFF, 1'b0},
    '{ROW_ITEM, REQ_COMPUTE,    16'd1,     16'h0000, 1'b1, 16'sh0000, 1'b1},
    '{ROW_ITEM, REQ_COMPUTE,    16'hFFFF,  16'h0000, 1'b1, 16'sh0000, 1'b1},
    '{ROW_ITEM, REQ_WRITE,      16'h1000,  16'h1234, 1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_WRITE,      16'hFFFF,  16'h5A5A, 1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_WRITE,      16'd0,     16'h8000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_COMPUTE,    16'd0,     16'h0000, 1'b1, 16'sh8000, 1'b0},
    '{ROW_REG,  REG_OUT_FRAMES, 16'd0,     16'h0000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_COMPUTE,    16'd0,     16'h0000, 1'b1, 16'sh0000, 1'b1},
    '{ROW_REG,  REG_IN_FRAMES,  16'd0,     16'hFFFF, 1'b0, 16'sh0000, 1'b0},
    '{ROW_REG,  REG_OUT_FRAMES, 16'd0,     16'hFFFF, 1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_WRITE,      16'd4095,  16'h0001, 1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_COMPUTE,    16'd65534, 16'h0000, 1'b1, 16'sh0001, 1'b0},
    '{ROW_ITEM, REQ_COMPUTE,    16'd65535, 16'h0000, 1'b1, 16'sh0000, 1'b1},
    '{ROW_REG,  REG_IN_FRAMES,  16'd0,     16'd3,    1'b0, 16'sh0000, 1'b0},
    '{ROW_REG,  REG_OUT_FRAMES, 16'd0,     16'd4,    1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_WRITE,      16'd1,     16'h7FFF, 1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_WRITE,      16'd2,     16'h0000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_COMPUTE,    16'd0,     16'h0000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_COMPUTE,    16'd1,     16'h0000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_COMPUTE,    16'd2,     16'h0000, 1'b0, 16'sh0000, 1'b0},
    '{ROW_ITEM, REQ_COMPUTE,    16'd3,     16'h0000, 1'b0, 16'sh0000, 1'b0},
    // upper bits are dropped, zero count saturates to one frame
    '{ROW_REG,  REG_IN_FRAMES,  16'd0,     16'hE000, 1'b0, 16'sh0000, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata;  // position[15:0], write_sample[31:16]
  logic s_tuser;                // req_type
  logic m_tvalid;
  logic m_tready;
  logic [TDATA_W-1:0] m_tdata;  // out_sample[15:0], out_position[31:16]
  logic m_tuser;                // out_of_range
  logic cfg_we;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // mirror of the block's state
  sample_t sample_mirror [MAX_FRAMES];
  bit sample_written [MAX_FRAMES];
  int unsigned in_frames;
  int unsigned out_frames;

  out_result_t pending_outputs [$];
  out_result_t want;

  bit calm;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned errors;
  int unsigned n_items, n_writes, n_dropped, n_settings;
  int unsigned n_checked, n_oor;

  always #1 clk = ~clk;

  linear_interpolation_resampler #(
    .MAX_INPUT_FRAMES(MAX_FRAMES),
    .FRACTION_BITS(FRAC_BITS)
  ) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic out_result_t interp_output(input pos_t idx);
    out_result_t r;
    longint unsigned num, whole, rem, frac, acc, lo, hi;
    r.pos = idx;
    r.oor = 1'b0;
    r.smp = '0;
    if (idx >= out_frames) begin
      r.oor = 1'b1;
      return r;
    end
    num = longint'(idx) * in_frames;
    whole = num / out_frames;
    rem = num % out_frames;
    frac = (rem << FRAC_BITS) / out_frames;
    if (whole + 1 >= in_frames) begin
      r.smp = sample_mirror[whole];
    end else begin
      // bias to non-negative so the floor is a plain shift
      lo = longint'(sample_mirror[whole]) + 32768;
      hi = longint'(sample_mirror[whole + 1]) + 32768;
      acc = lo * ((64'd1 << FRAC_BITS) - frac) + hi * frac;
      r.smp = sample_t'((acc >> FRAC_BITS) - 32768);
    end
    return r;
  endfunction

  function automatic void apply_reg(input logic idx, input logic [15:0] value);
    int unsigned v;
    if (idx == REG_IN_FRAMES) begin
      v = value & 16'h1FFF;
      if (v < 1) v = 1;
      if (v > MAX_FRAMES) v = MAX_FRAMES;
      in_frames = v;
    end else begin
      out_frames = value;
    end
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic req, input pos_t pos, input sample_t smp,
                           input bit typed = 1'b0, input sample_t t_smp = '0,
                           input logic t_oor = 1'b0);
    out_result_t r;
    if ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {smp, pos};
    do @(posedge clk); while (!s_tready);
    // transfer taken at this edge
    if (req == REQ_WRITE) begin
      if (pos < MAX_FRAMES) begin
        sample_mirror[pos] = smp;
        sample_written[pos] = 1'b1;
        n_writes++;
        n_items++;
      end else begin
        n_dropped++;
      end
    end else begin
      r = interp_output(pos);
      if (typed) begin
        r.smp = t_smp;
        r.oor = t_oor;
      end
      pending_outputs.push_back(r);
      n_items++;
    end
  endtask

  // make sure both neighbors are defined before asking for an output
  task automatic request_output(input pos_t idx);
    longint unsigned whole;
    whole = (longint'(idx) * in_frames) / out_frames;
    if (!sample_written[whole])
      send_item(REQ_WRITE, pos_t'(whole), rand_sample());
    if (whole + 1 < in_frames && !sample_written[whole + 1])
      send_item(REQ_WRITE, pos_t'(whole + 1), rand_sample());
    send_item(REQ_COMPUTE, idx, sample_t'($urandom));
  endtask

  task automatic random_item();
    int unsigned k;
    pos_t idx;
    k = $urandom_range(0, 99);
    if (out_frames == 0 || k >= 94) begin
      idx = pos_t'($urandom_range(out_frames, 65535));
      send_item(REQ_COMPUTE, idx, sample_t'($urandom));
    end else if (k < 70) begin
      case ($urandom_range(0, 9))
        0: idx = '0;
        1: idx = pos_t'(out_frames - 1);
        default: idx = pos_t'($urandom_range(0, out_frames - 1));
      endcase
      request_output(idx);
    end else if (k < 80) begin
      send_item(REQ_WRITE, pos_t'($urandom_range(0, in_frames - 1)), rand_sample());
    end else if (k < 88) begin
      send_item(REQ_WRITE, pos_t'($urandom_range(0, MAX_FRAMES - 1)), rand_sample());
    end else begin
      send_item(REQ_WRITE, pos_t'($urandom_range(MAX_FRAMES, 65535)), rand_sample());
    end
  endtask

  // writes give no result, so leave time for one still in flight
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    apply_reg(idx, value);
    n_settings++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected result: out_position %0d", m_tdata[31:16]);
        errors++;
      end else begin
        want = pending_outputs.pop_front();
        n_checked++;
        if (want.oor) n_oor++;
        if (m_tdata[15:0] !== want.smp) begin
          $error("out_sample: expected %0d, got %0d", want.smp, $signed(m_tdata[15:0]));
          errors++;
        end
        if (m_tdata[31:16] !== want.pos) begin
          $error("out_position: expected %0d, got %0d", want.pos, m_tdata[31:16]);
          errors++;
        end
        if (m_tuser !== want.oor) begin
          $error("out_of_range: expected %0d, got %0d", want.oor, m_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** linear_interpolation_resampler: FAILED **");
    $finish;
  end

  initial begin
    int unsigned target;
    logic [15:0] in_raw, out_raw;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_WRITE;
    cfg_we = 1'b0;
    cfg_index = REG_IN_FRAMES;
    cfg_data = '0;
    calm = 1'b0;
    gap_pct = 20;
    stall_pct = 15;
    in_frames = 1;
    out_frames = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_REG) begin
        settle();
        write_reg(DIRECTED_ROWS[i].sel, DIRECTED_ROWS[i].value);
      end else begin
        send_item(DIRECTED_ROWS[i].sel, DIRECTED_ROWS[i].pos,
                  sample_t'(DIRECTED_ROWS[i].value), DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].want_smp, DIRECTED_ROWS[i].want_oor);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin in_raw = 16'h0000; out_raw = 16'hFFFF; end
        1: begin in_raw = 16'd4096; out_raw = 16'd1;    end
        2: begin in_raw = 16'd2;    out_raw = 16'h0000; end
        3: begin in_raw = 16'd4097; out_raw = 16'd3;    end
        4: begin in_raw = 16'd1;    out_raw = 16'd1;    end
        default: begin
          in_raw = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
          out_raw = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 120));
        end
      endcase
      write_reg(REG_IN_FRAMES, in_raw);
      write_reg(REG_OUT_FRAMES, out_raw);
      calm = (p >= PHASES - 2);
      gap_pct = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
      target = n_items + ITEMS_PER_PHASE;
      while (n_items < target) random_item();
    end
    settle();

    $display("covered %0d requests: %0d sample writes, %0d writes past the store, %0d outputs",
             n_items + n_dropped, n_writes, n_dropped, n_checked);
    $display("%0d outputs flagged out of range, %0d register writes, %0d mismatches",
             n_oor, n_settings, errors);
    if (errors == 0) begin
      $display("** linear_interpolation_resampler: PASSED **");
    end else begin
      $display("** linear_interpolation_resampler: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/lir_pkg.sv
hdl/lir_ram.sv
hdl/lir_div.sv
hdl/linear_interpolation_resampler.sv
test/tb_top.sv
